// ----- src/wlbcd_pkg.sv -----
`default_nettype none
package wlbcd_pkg;
    localparam int LBA_W = 48;
    localparam int STAMP_W = 32;
    localparam int CNT_W = 32;

    typedef enum logic [2:0] {
        MODE_GET = 3'd0,
        MODE_DIRTY = 3'd1,
        MODE_WTHRU = 3'd2,
        MODE_FLUSH = 3'd3,
        MODE_INVAL = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        K_HIT = 3'd0,
        K_FILL = 3'd1,
        K_WBACK = 3'd2,
        K_WTHRU = 3'd3,
        K_DONE = 3'd4,
        K_ERR = 3'd5
    } kind_t;

    localparam logic [0:0] REG_DRIVE_PRESENT = 1'd0;
endpackage
`default_nettype wire

// ----- src/wlbcd_tag_ram.sv -----
`default_nettype none
// Tag and stamp store: one write port, one registered read port.
module wlbcd_tag_ram #(
    parameter int SLOTS = 32,
    parameter int IW = 5
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [IW-1:0]             waddr,
    input  wire logic [wlbcd_pkg::LBA_W-1:0]   wsector,
    input  wire logic [1:0]                wdrive,
    input  wire logic [wlbcd_pkg::STAMP_W-1:0] wstamp,
    input  wire logic [IW-1:0]             raddr,
    output logic [wlbcd_pkg::LBA_W-1:0]    rsector,
    output logic [1:0]                     rdrive,
    output logic [wlbcd_pkg::STAMP_W-1:0]  rstamp
);
    import wlbcd_pkg::*;
    logic [LBA_W+2+STAMP_W-1:0] mem [SLOTS];
    logic [LBA_W+2+STAMP_W-1:0] rd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wsector, wdrive, wstamp};
        end
        rd <= mem[raddr];
    end

    assign rsector = rd[LBA_W+2+STAMP_W-1:2+STAMP_W];
    assign rdrive = rd[STAMP_W+1:STAMP_W];
    assign rstamp = rd[STAMP_W-1:0];
endmodule
`default_nettype wire

// ----- src/writeback_lru_block_cache_directory_top.sv -----
`default_nettype none
// Flow: an accepted request scans the tag memory, decides in S_DEC and gives its final
// result from S_FIN; a dirty victim on a present drive is first written back from S_WB.
// A new request is taken only back in S_IDLE, so requests never overlap; the serial scan
// of the tag memory, one entry a cycle unless paused, sets the pace. A flush sends its
// write-backs during the scan and pauses the scan while the result register is still full.
// Reset: valid and dirty flags, use clock, counters and drive_present clear at once;
// the tag memory is not cleared, as it is only read for valid slots.
module writeback_lru_block_cache_directory_top #(
    parameter int SLOTS = 32,
    parameter int DRIVES = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [2:0]  drive,
    input  wire logic [47:0] lba,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [4:0]       slot,
    output logic [1:0]       out_drive,
    output logic [47:0]      out_lba,
    output logic             last,
    output logic [31:0]      hit_count,
    output logic [31:0]      miss_count,
    output logic [31:0]      write_count
);
    import wlbcd_pkg::*;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_I = IW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_WB   = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] present_reg;
    logic [SLOTS-1:0] valid_reg, valid_next, dirty_reg, dirty_next;
    logic [31:0] clock_reg, clock_next, hits_reg, hits_next;
    logic [31:0] misses_reg, misses_next, writes_reg, writes_next;
    logic [2:0] mode_reg;
    logic [2:0] drive_reg;
    logic [47:0] lba_reg;
    logic [IW-1:0] rd_i_reg;      // index of the read data this cycle
    logic match_v_reg;
    logic [IW-1:0] match_i_reg;
    logic clean_v_reg;
    logic [IW-1:0] clean_i_reg;
    logic [31:0] clean_s_reg;
    logic [IW-1:0] all_i_reg;
    logic [31:0] all_s_reg;
    logic [47:0] all_sec_reg;
    logic [1:0] all_drv_reg;
    logic [IW-1:0] vict_reg, vict_next;
    // flush write-back held back until it is known whether it is the last
    logic hold_v_reg;
    logic [IW-1:0] hold_i_reg;
    logic [47:0] hold_lba_reg;
    logic [31:0] hold_w_reg;
    // output register
    logic ov_reg;
    logic [2:0] ok_reg;
    logic [4:0] os_reg;
    logic [1:0] od_reg;
    logic [47:0] ol_reg;
    logic olast_reg;
    logic [31:0] oh_reg, om_reg, ow_reg;

    logic we;
    logic [IW-1:0] waddr, raddr;
    logic [47:0] wsec, rsec;
    logic [1:0] wdrv, rdrv;
    logic [31:0] wstamp, rstamp;

    wlbcd_tag_ram #(.SLOTS(SLOTS), .IW(IW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wsector(wsec), .wdrive(wdrv),
        .wstamp(wstamp), .raddr(raddr), .rsector(rsec), .rdrive(rdrv), .rstamp(rstamp)
    );

    logic drv_ok, drv_pres;
    assign drv_ok = {29'd0, drive_reg} < DRIVES;
    assign drv_pres = drv_ok && drive_reg[2] == 1'b0 && present_reg[drive_reg[1:0]];

    logic out_free;
    assign out_free = !ov_reg || !out_stall;

    assign pready = 1'b1;
    assign prdata = {28'd0, present_reg};
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign kind = ok_reg;
    assign slot = os_reg;
    assign out_drive = od_reg;
    assign out_lba = ol_reg;
    assign last = olast_reg;
    assign hit_count = oh_reg;
    assign miss_count = om_reg;
    assign write_count = ow_reg;

    logic rv, rmatch, rflush, scan_hold;
    assign rv = valid_reg[rd_i_reg];
    assign rmatch = rv && drive_reg[2] == 1'b0 && rdrv == drive_reg[1:0];
    assign rflush = (state_reg == S_SCAN) && mode_reg == MODE_FLUSH && drv_pres && rmatch
                    && dirty_reg[rd_i_reg];
    assign scan_hold = rflush && hold_v_reg && !out_free;
    // re-read the same entry while the scan is paused
    assign raddr = (state_reg != S_SCAN) ? '0
                 : (scan_hold || rd_i_reg == LAST_I) ? rd_i_reg : rd_i_reg + IW'(1);

    // lowest invalid slot
    logic inv_any;
    logic [IW-1:0] inv_i;
    always_comb
    begin
        inv_i = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                inv_i = IW'(i);
        end
    end
    assign inv_any = !(&valid_reg);

    logic vict_wb, miss_evict;
    logic [IW-1:0] victim;
    assign victim = inv_any ? inv_i : (clean_v_reg ? clean_i_reg : all_i_reg);
    assign vict_wb = !inv_any && !clean_v_reg;
    assign miss_evict = (mode_reg == MODE_GET || mode_reg == MODE_WTHRU) && drv_ok
                        && !match_v_reg;

    logic emit, e_last, e_held;
    kind_t e_kind;
    logic [4:0] e_slot;
    logic [1:0] e_drv;
    logic [47:0] e_lba;
    logic [31:0] e_writes;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        clock_next = clock_reg;
        hits_next = hits_reg;
        misses_next = misses_reg;
        writes_next = writes_reg;
        vict_next = vict_reg;
        emit = 1'b0;
        e_kind = K_DONE;
        e_slot = 5'd0;
        e_drv = 2'd0;
        e_lba = 48'd0;
        e_last = 1'b1;
        e_held = 1'b0;
        we = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (!scan_hold)
                begin
                    if (mode_reg == MODE_INVAL && rmatch)
                        valid_next[rd_i_reg] = 1'b0;
                    if (rflush)
                    begin
                        dirty_next[rd_i_reg] = 1'b0;
                        writes_next = writes_reg + 32'd1;
                        // the held write-back is now known not to be the last
                        if (hold_v_reg)
                        begin
                            emit = 1'b1;
                            e_kind = K_WBACK;
                            e_slot = 5'(hold_i_reg);
                            e_drv = drive_reg[1:0];
                            e_lba = hold_lba_reg;
                            e_last = 1'b0;
                            e_held = 1'b1;
                        end
                    end
                    if (rd_i_reg == LAST_I)
                        state_next = S_DEC;
                end
            S_DEC:
            begin
                vict_next = match_v_reg ? match_i_reg : victim;
                state_next = S_FIN;
                if (miss_evict)
                begin
                    if (mode_reg == MODE_GET)
                        misses_next = misses_reg + 32'd1;
                    valid_next[victim] = 1'b0;
                    if (vict_wb)
                    begin
                        dirty_next[victim] = 1'b0;
                        writes_next = writes_reg + 32'd1;
                        if (present_reg[all_drv_reg])
                            state_next = S_WB;
                    end
                end
            end
            S_WB:
                if (out_free)
                begin
                    emit = 1'b1;
                    e_kind = K_WBACK;
                    e_slot = 5'(vict_reg);
                    e_drv = all_drv_reg;
                    e_lba = all_sec_reg;
                    e_last = 1'b0;
                    state_next = S_FIN;
                end
            S_FIN:
                if (out_free)
                begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                    e_kind = K_ERR;
                    case (mode_reg)
                        MODE_GET:
                            if (drv_ok && match_v_reg)
                            begin
                                hits_next = hits_reg + 32'd1;
                                clock_next = clock_reg + 32'd1;
                                we = 1'b1;
                                e_kind = K_HIT;
                                e_slot = 5'(vict_reg);
                                e_drv = drive_reg[1:0];
                                e_lba = lba_reg;
                            end
                            else if (drv_pres)
                            begin
                                valid_next[vict_reg] = 1'b1;
                                dirty_next[vict_reg] = 1'b0;
                                clock_next = clock_reg + 32'd1;
                                we = 1'b1;
                                e_kind = K_FILL;
                                e_slot = 5'(vict_reg);
                                e_drv = drive_reg[1:0];
                                e_lba = lba_reg;
                            end
                        MODE_DIRTY:
                        begin
                            e_kind = K_DONE;
                            if (match_v_reg)
                            begin
                                dirty_next[match_i_reg] = 1'b1;
                                e_slot = 5'(match_i_reg);
                            end
                        end
                        MODE_WTHRU:
                            if (drv_ok)
                            begin
                                // the slot keeps its new tag even for an absent drive
                                valid_next[vict_reg] = 1'b1;
                                dirty_next[vict_reg] = 1'b0;
                                clock_next = clock_reg + 32'd1;
                                we = 1'b1;
                                if (drv_pres)
                                begin
                                    writes_next = writes_reg + 32'd1;
                                    e_kind = K_WTHRU;
                                    e_slot = 5'(vict_reg);
                                    e_drv = drive_reg[1:0];
                                    e_lba = lba_reg;
                                end
                            end
                        MODE_FLUSH:
                            if (drv_pres)
                            begin
                                if (hold_v_reg)
                                begin
                                    e_kind = K_WBACK;
                                    e_slot = 5'(hold_i_reg);
                                    e_drv = drive_reg[1:0];
                                    e_lba = hold_lba_reg;
                                    e_held = 1'b1;
                                end
                                else
                                    e_kind = K_DONE;
                            end
                        MODE_INVAL:
                            e_kind = K_DONE;
                        default:
                            e_kind = K_ERR;
                    endcase
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign e_writes = e_held ? hold_w_reg : writes_next;
    assign waddr = vict_reg;
    assign wsec = lba_reg;
    assign wdrv = drive_reg[1:0];
    assign wstamp = clock_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            present_reg <= 4'd0;
            valid_reg <= '0;
            dirty_reg <= '0;
            clock_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
            writes_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready
                && paddr == {REG_DRIVE_PRESENT, 1'b0})
                present_reg <= pwdata[3:0];
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            clock_reg <= clock_next;
            hits_reg <= hits_next;
            misses_reg <= misses_next;
            writes_reg <= writes_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // request payload, scan trackers and result payload
    always_ff @(posedge clk)
    begin
        vict_reg <= vict_next;
        if (emit)
        begin
            ok_reg <= e_kind;
            os_reg <= e_slot;
            od_reg <= e_drv;
            ol_reg <= e_lba;
            olast_reg <= e_last;
            oh_reg <= hits_next;
            om_reg <= misses_next;
            ow_reg <= e_writes;
        end
        if (state_reg == S_IDLE)
        begin
            mode_reg <= mode;
            drive_reg <= drive;
            lba_reg <= lba;
            rd_i_reg <= '0;
            match_v_reg <= 1'b0;
            clean_v_reg <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN && !scan_hold)
        begin
            if (rd_i_reg != LAST_I)
                rd_i_reg <= rd_i_reg + IW'(1);
            if (rmatch && rsec == lba_reg && !match_v_reg)
            begin
                match_v_reg <= 1'b1;
                match_i_reg <= rd_i_reg;
            end
            if (rv && !dirty_reg[rd_i_reg] && (!clean_v_reg || rstamp < clean_s_reg))
            begin
                clean_v_reg <= 1'b1;
                clean_i_reg <= rd_i_reg;
                clean_s_reg <= rstamp;
            end
            if (rd_i_reg == '0 || rstamp < all_s_reg)
            begin
                all_i_reg <= rd_i_reg;
                all_s_reg <= rstamp;
                all_sec_reg <= rsec;
                all_drv_reg <= rdrv;
            end
            if (rflush)
            begin
                hold_v_reg <= 1'b1;
                hold_i_reg <= rd_i_reg;
                hold_lba_reg <= rsec;
                hold_w_reg <= writes_reg + 32'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("accept while busy");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free) else $error("result overwrite");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(slot)
        && $stable(out_lba))) else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
